// File: hw/rtl/hci_h4_packet_deframer_assert.svh
// Assertion macros for the HCI H4 deframer.
// Each macro assumes clk and arst_n are in scope at the point of use.
`ifndef HCI_H4_PACKET_DEFRAMER_ASSERT_SVH
`define HCI_H4_PACKET_DEFRAMER_ASSERT_SVH

`ifndef SYNTH

// Condition must hold at every clock edge out of reset.
`define HCIH4_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("hcih4: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define HCIH4_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcih4: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define HCIH4_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcih4: next-cycle implication violated");

`else

`define HCIH4_ASSERT_ALWAYS(lbl, cond)
`define HCIH4_ASSERT_IMPL(lbl, ante, cons)
`define HCIH4_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/hcih4_pkg.sv
package hcih4_pkg;

	// Default hard ceiling on header plus payload length
	localparam int unsigned MAX_FRAME_BYTES_DEF = 4096;

	// Width of the length compare: four header bytes plus a 16-bit payload length
	localparam int unsigned CMP_W = 17;

	localparam int unsigned LIMIT_W = 13;
	localparam logic [LIMIT_W-1:0] MAX_FRAME_LEN_RST = 13'd1028;

	// H4 packet indicator bytes
	localparam logic [7:0] TYPE_ACL = 8'h02;
	localparam logic [7:0] TYPE_SCO = 8'h03;
	localparam logic [7:0] TYPE_EVT = 8'h04;

	localparam logic [1:0] KIND_EVT = 2'd0;
	localparam logic [1:0] KIND_ACL = 2'd1;
	localparam logic [1:0] KIND_SCO = 2'd2;

	localparam logic [1:0] ROLE_TYPE    = 2'd0;
	localparam logic [1:0] ROLE_HEADER  = 2'd1;
	localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
	localparam logic [1:0] ROLE_DROP    = 2'd3;

	typedef enum logic [4:0] {
		PH_TYPE = 5'b00001,
		PH_EVT  = 5'b00010,
		PH_ACL  = 5'b00100,
		PH_SCO  = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [1:0]  packet_kind;
		logic [1:0]  byte_role;
		logic [11:0] frame_offset;
		logic        frame_end;
		logic        bad_type;
		logic        too_long;
	} res_t;

	function automatic logic [2:0] header_size(input logic [1:0] kind);
		logic [2:0] hs;
		unique case (kind)
			KIND_EVT: hs = 3'd2;
			KIND_ACL: hs = 3'd4;
			default:  hs = 3'd3;
		endcase
		return hs;
	endfunction

endpackage

// File: hw/rtl/hcih4_parse.sv
// Frame tracker: classifies one word per step and holds the framing state.
module hcih4_parse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [7:0]                   rx_byte,
	input  logic [hcih4_pkg::CMP_W-1:0]  limit,
	output hcih4_pkg::res_t              res
);

	`include "hci_h4_packet_deframer_assert.svh"

	hcih4_pkg::phase_t phase_q, phase_nxt;
	logic [15:0] bytes_left_q, bytes_left_nxt, bl_dec;
	logic [12:0] fill_q, fill_nxt, fill_inc;
	logic [1:0]  kind_q, kind_nxt;
	// Only header byte 2 is ever read back (low length byte of ACL); the
	// other header bytes are either ignored or consumed on the wire.
	logic [7:0]  hdr2_q;
	logic        hdr2_we;
	logic [15:0] plen;
	logic [hcih4_pkg::CMP_W-1:0] total;

	assign bl_dec   = bytes_left_q - 16'd1;
	assign fill_inc = fill_q + 13'd1;
	assign plen     = (kind_q == hcih4_pkg::KIND_ACL) ? {rx_byte, hdr2_q} : {8'd0, rx_byte};
	assign total    = {{(hcih4_pkg::CMP_W-3){1'b0}}, hcih4_pkg::header_size(kind_q)}
			+ {{(hcih4_pkg::CMP_W-16){1'b0}}, plen};

	always_comb begin
		phase_nxt      = phase_q;
		bytes_left_nxt = bytes_left_q;
		fill_nxt       = fill_q;
		kind_nxt       = kind_q;
		hdr2_we        = 1'b0;
		res            = '0;
		res.data_byte  = rx_byte;
		res.byte_role  = hcih4_pkg::ROLE_DROP;
		unique case (phase_q)
			hcih4_pkg::PH_EVT, hcih4_pkg::PH_ACL, hcih4_pkg::PH_SCO: begin
				res.packet_kind  = kind_q;
				res.byte_role    = hcih4_pkg::ROLE_HEADER;
				res.frame_offset = fill_q[11:0];
				hdr2_we          = (fill_q[1:0] == 2'd2);
				fill_nxt         = fill_inc;
				bytes_left_nxt   = bl_dec;
				if (bl_dec == 16'd0) begin
					// Last header byte: check the length, then end, abandon or go to payload
					if (total > limit) begin
						res.too_long = 1'b1;
						phase_nxt    = hcih4_pkg::PH_TYPE;
					end else if (plen == 16'd0) begin
						res.frame_end = 1'b1;
						phase_nxt     = hcih4_pkg::PH_TYPE;
					end else begin
						bytes_left_nxt = plen;
						phase_nxt      = hcih4_pkg::PH_DATA;
					end
				end
			end
			hcih4_pkg::PH_DATA: begin
				res.packet_kind  = kind_q;
				res.byte_role    = hcih4_pkg::ROLE_PAYLOAD;
				res.frame_offset = fill_q[11:0];
				fill_nxt         = fill_inc;
				bytes_left_nxt   = bl_dec;
				if (bl_dec == 16'd0) begin
					res.frame_end = 1'b1;
					phase_nxt     = hcih4_pkg::PH_TYPE;
				end
			end
			default: begin
				// Waiting for a packet indicator
				fill_nxt  = '0;
				phase_nxt = hcih4_pkg::PH_TYPE;
				res.byte_role = hcih4_pkg::ROLE_TYPE;
				priority if (rx_byte == hcih4_pkg::TYPE_EVT) begin
					kind_nxt  = hcih4_pkg::KIND_EVT;
					phase_nxt = hcih4_pkg::PH_EVT;
				end else if (rx_byte == hcih4_pkg::TYPE_ACL) begin
					kind_nxt  = hcih4_pkg::KIND_ACL;
					phase_nxt = hcih4_pkg::PH_ACL;
				end else if (rx_byte == hcih4_pkg::TYPE_SCO) begin
					kind_nxt  = hcih4_pkg::KIND_SCO;
					phase_nxt = hcih4_pkg::PH_SCO;
				end else begin
					res.byte_role = hcih4_pkg::ROLE_DROP;
					res.bad_type  = 1'b1;
				end
				if (res.bad_type) begin
					bytes_left_nxt = '0;
				end else begin
					bytes_left_nxt  = {13'd0, hcih4_pkg::header_size(kind_nxt)};
					res.packet_kind = kind_nxt;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= hcih4_pkg::PH_TYPE;
			bytes_left_q <= '0;
			fill_q       <= '0;
			kind_q       <= hcih4_pkg::KIND_EVT;
		end else if (step) begin
			phase_q      <= phase_nxt;
			bytes_left_q <= bytes_left_nxt;
			fill_q       <= fill_nxt;
			kind_q       <= kind_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hdr2_we) begin
			hdr2_q <= rx_byte;
		end
	end

	// Header countdown never starts above four and never sits at zero
	`HCIH4_ASSERT_IMPL(a_hdr_count, (phase_q == hcih4_pkg::PH_EVT || phase_q == hcih4_pkg::PH_ACL || phase_q == hcih4_pkg::PH_SCO), (bytes_left_q != 16'd0 && bytes_left_q <= 16'd4 && fill_q < 13'd4))
	`HCIH4_ASSERT_IMPL(a_data_count, (phase_q == hcih4_pkg::PH_DATA), (bytes_left_q != 16'd0))
	// Any word that closes or drops a frame leaves the tracker hunting for a type
	`HCIH4_ASSERT_NEXT(a_close_to_type, (step && (res.frame_end || res.too_long || res.bad_type)), (phase_q == hcih4_pkg::PH_TYPE))
	`HCIH4_ASSERT_ALWAYS(a_one_outcome, (!(res.frame_end && res.too_long) && !(res.bad_type && (res.frame_end || res.too_long))))

endmodule

// File: hw/rtl/hci_h4_packet_deframer.sv
// Channel  | Handshake             | Fields
// ---------+-----------------------+------------------------------------------------
// input    | in_valid / in_ready   | rx_byte
// output   | out_valid / out_ready | data_byte through too_long, in port order
// config   | cfg_wr_en (no wait)   | cfg_wr_data -> max_frame_len
//
// One word in, one word out through the input register and the output register;
// one word per cycle sustained while out_ready is high; the rate is set by the single
// framing step (a 17-bit length add and compare) between the two registers.
// arst_n clears the framing state, both valid flags and sets max_frame_len to 1028.
// A stalled output holds its word while the input register still takes one more;
// in_ready drops only when both registers are full and out_ready is low.
module hci_h4_packet_deframer #(
	parameter int unsigned MAX_FRAME_BYTES = hcih4_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic [hcih4_pkg::LIMIT_W-1:0]   cfg_wr_data,
	// received bytes
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	// classified bytes
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      data_byte,
	output logic [1:0]                      packet_kind,
	output logic [1:0]                      byte_role,
	output logic [11:0]                     frame_offset,
	output logic                            frame_end,
	output logic                            bad_type,
	output logic                            too_long
);

	localparam logic [hcih4_pkg::CMP_W-1:0] HARD_LIMIT =
		MAX_FRAME_BYTES[hcih4_pkg::CMP_W-1:0];

	logic [hcih4_pkg::LIMIT_W-1:0] max_frame_len_q;
	logic [hcih4_pkg::CMP_W-1:0]   cfg_limit, limit;

	logic            valid_s1, valid_s2;
	logic [7:0]      byte_s1;
	hcih4_pkg::res_t res, res_s2;
	logic            advance, step;

	// Hold the register; the user writes only while the block is idle (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= hcih4_pkg::MAX_FRAME_LEN_RST;
		end else if (cfg_wr_en) begin
			max_frame_len_q <= cfg_wr_data;
		end
	end

	// Effective limit is the smaller of the register and the hard ceiling
	assign cfg_limit = {{(hcih4_pkg::CMP_W-hcih4_pkg::LIMIT_W){1'b0}}, max_frame_len_q};
	assign limit     = (cfg_limit < HARD_LIMIT) ? cfg_limit : HARD_LIMIT;

	// Advance the input stage whenever the output register is free or draining
	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	// Classify the held word and move the framing state by one step
	hcih4_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.limit   (limit),
		.res     (res)
	);

	assign out_valid    = valid_s2;
	assign data_byte    = res_s2.data_byte;
	assign packet_kind  = res_s2.packet_kind;
	assign byte_role    = res_s2.byte_role;
	assign frame_offset = res_s2.frame_offset;
	assign frame_end    = res_s2.frame_end;
	assign bad_type     = res_s2.bad_type;
	assign too_long     = res_s2.too_long;

endmodule

// File: test/hci_h4_packet_deframer_tb.sv
module hci_h4_packet_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Hard ceiling on header plus payload, as built into the instance below
	localparam int unsigned FRAME_CEILING = hcih4_pkg::MAX_FRAME_BYTES_DEF;
	// Long output stall: starts once this many words have drained
	localparam int unsigned HOLD_AT_WORD = 150;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef enum logic [4:0] {
		AWAIT_TYPE = 5'b00001,
		EVT_HDR    = 5'b00010,
		ACL_HDR    = 5'b00100,
		SCO_HDR    = 5'b01000,
		PAYLOAD    = 5'b10000
	} rx_state_t;

	typedef struct {
		logic [7:0]      rx;
		bit              typed;
		hcih4_pkg::res_t want;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [hcih4_pkg::LIMIT_W-1:0] cfg_wr_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [7:0]                    rx_byte;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [7:0]                    data_byte;
	logic [1:0]                    packet_kind;
	logic [1:0]                    byte_role;
	logic [11:0]                   frame_offset;
	logic                          frame_end;
	logic                          bad_type;
	logic                          too_long;

	// Predictor copy of the framing state and the limit register
	rx_state_t                     fr_state;
	logic [15:0]                   fr_left;
	logic [7:0]                    fr_hdr [4];
	logic [12:0]                   fr_fill;
	logic [1:0]                    fr_kind;
	logic [hcih4_pkg::LIMIT_W-1:0] fr_limit;

	hcih4_pkg::res_t               tagged_bytes_q [$];
	int unsigned                   mismatches = 0;
	int unsigned                   bytes_sent = 0;
	int unsigned                   feed_gap_pct;
	int unsigned                   drain_gap_pct;
	int unsigned                   words_taken = 0;
	int unsigned                   hold_left = 0;
	bit                            hold_done = 1'b0;

	// Directed bytes. Rows with a typed word hold the obvious answers: the
	// unknown type bytes, type bytes, the zero-length event end and the
	// too-long ACL abandon. Everything else goes through the predictor.
	stim_row_t directed_rows [24] = '{
		'{8'h00, 1'b1, '{8'h00, hcih4_pkg::KIND_EVT, hcih4_pkg::ROLE_DROP,
			12'd0, 1'b0, 1'b1, 1'b0}},
		'{8'hFF, 1'b1, '{8'hFF, hcih4_pkg::KIND_EVT, hcih4_pkg::ROLE_DROP,
			12'd0, 1'b0, 1'b1, 1'b0}},
		'{8'h04, 1'b1, '{8'h04, hcih4_pkg::KIND_EVT, hcih4_pkg::ROLE_TYPE,
			12'd0, 1'b0, 1'b0, 1'b0}},
		'{8'h7F, 1'b0, '0},
		'{8'h00, 1'b1, '{8'h00, hcih4_pkg::KIND_EVT, hcih4_pkg::ROLE_HEADER,
			12'd1, 1'b1, 1'b0, 1'b0}},
		'{8'h02, 1'b1, '{8'h02, hcih4_pkg::KIND_ACL, hcih4_pkg::ROLE_TYPE,
			12'd0, 1'b0, 1'b0, 1'b0}},
		'{8'h01, 1'b0, '0},
		'{8'h20, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hAA, 1'b0, '0},
		'{8'h55, 1'b0, '0},
		'{8'h03, 1'b1, '{8'h03, hcih4_pkg::KIND_SCO, hcih4_pkg::ROLE_TYPE,
			12'd0, 1'b0, 1'b0, 1'b0}},
		'{8'h10, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b1, '{8'hFF, hcih4_pkg::KIND_ACL, hcih4_pkg::ROLE_HEADER,
			12'd3, 1'b0, 1'b0, 1'b1}},
		'{8'h01, 1'b1, '{8'h01, hcih4_pkg::KIND_EVT, hcih4_pkg::ROLE_DROP,
			12'd0, 1'b0, 1'b1, 1'b0}},
		'{8'h05, 1'b1, '{8'h05, hcih4_pkg::KIND_EVT, hcih4_pkg::ROLE_DROP,
			12'd0, 1'b0, 1'b1, 1'b0}}
	};

	hci_h4_packet_deframer #(
		.MAX_FRAME_BYTES(FRAME_CEILING)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_byte   (data_byte),
		.packet_kind (packet_kind),
		.byte_role   (byte_role),
		.frame_offset(frame_offset),
		.frame_end   (frame_end),
		.bad_type    (bad_type),
		.too_long    (too_long)
	);

	always begin
		#4ns clk = 1'b1;
		#4ns clk = 1'b0;
	end

	function automatic int unsigned hdr_len(input logic [1:0] kind);
		if (kind == hcih4_pkg::KIND_EVT)
			return 2;
		if (kind == hcih4_pkg::KIND_ACL)
			return 4;
		return 3;
	endfunction

	// The register is clipped by the built-in ceiling
	function automatic int unsigned eff_limit();
		return (fr_limit > FRAME_CEILING) ? FRAME_CEILING : {19'd0, fr_limit};
	endfunction

	// Classify one received byte and advance the predicted framing state
	function automatic hcih4_pkg::res_t tag_byte(input logic [7:0] b);
		hcih4_pkg::res_t r;
		int unsigned     plen;
		r = '0;
		r.data_byte = b;
		case (fr_state)
			EVT_HDR, ACL_HDR, SCO_HDR: begin
				r.packet_kind = fr_kind;
				r.byte_role = hcih4_pkg::ROLE_HEADER;
				r.frame_offset = fr_fill[11:0];
				fr_hdr[fr_fill[1:0]] = b;
				fr_fill = fr_fill + 13'd1;
				fr_left = fr_left - 16'd1;
				if (fr_left == 16'd0) begin
					// Header complete: pull the payload length from its slot
					if (fr_kind == hcih4_pkg::KIND_EVT)
						plen = {24'd0, fr_hdr[1]};
					else if (fr_kind == hcih4_pkg::KIND_ACL)
						plen = {16'd0, fr_hdr[3], fr_hdr[2]};
					else
						plen = {24'd0, fr_hdr[2]};
					if (hdr_len(fr_kind) + plen > eff_limit()) begin
						r.too_long = 1'b1;
						fr_state = AWAIT_TYPE;
					end else if (plen == 0) begin
						// Empty payload: the last header byte closes the frame
						r.frame_end = 1'b1;
						fr_state = AWAIT_TYPE;
					end else begin
						fr_left = plen[15:0];
						fr_state = PAYLOAD;
					end
				end
			end
			PAYLOAD: begin
				r.packet_kind = fr_kind;
				r.byte_role = hcih4_pkg::ROLE_PAYLOAD;
				r.frame_offset = fr_fill[11:0];
				fr_fill = fr_fill + 13'd1;
				fr_left = fr_left - 16'd1;
				if (fr_left == 16'd0) begin
					r.frame_end = 1'b1;
					fr_state = AWAIT_TYPE;
				end
			end
			default: begin
				fr_state = AWAIT_TYPE;
				fr_fill = '0;
				if (b == hcih4_pkg::TYPE_EVT || b == hcih4_pkg::TYPE_ACL
						|| b == hcih4_pkg::TYPE_SCO) begin
					if (b == hcih4_pkg::TYPE_EVT) begin
						fr_kind = hcih4_pkg::KIND_EVT;
						fr_state = EVT_HDR;
					end else if (b == hcih4_pkg::TYPE_ACL) begin
						fr_kind = hcih4_pkg::KIND_ACL;
						fr_state = ACL_HDR;
					end else begin
						fr_kind = hcih4_pkg::KIND_SCO;
						fr_state = SCO_HDR;
					end
					fr_left = 16'(hdr_len(fr_kind));
					r.packet_kind = fr_kind;
					r.byte_role = hcih4_pkg::ROLE_TYPE;
				end else begin
					// Unknown type byte: drop it and keep hunting
					fr_left = '0;
					r.byte_role = hcih4_pkg::ROLE_DROP;
					r.bad_type = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// Offer one byte, hold it until taken, then queue its expected word.
	// Valid stays high on return so back-to-back bytes need no gap.
	task automatic send_byte(input logic [7:0] b, input bit typed,
			input hcih4_pkg::res_t want);
		hcih4_pkg::res_t pred;
		while ($urandom_range(99) < feed_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		pred = tag_byte(b);
		tagged_bytes_q.push_back(typed ? want : pred);
	endtask

	// Write the limit only once the block has drained
	task automatic set_limit(input logic [hcih4_pkg::LIMIT_W-1:0] value);
		in_valid <= 1'b0;
		while (tagged_bytes_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fr_limit = value;
	endtask

	// One random frame: mostly well formed, some noise, some cut short
	task automatic send_frame();
		int unsigned pick;
		int unsigned hs;
		int unsigned plen;
		int unsigned lim;
		int unsigned n_payload;
		logic [1:0]  kind;
		logic [7:0]  tbyte;
		logic [7:0]  hb [4];
		pick = $urandom_range(99);
		if (pick < 10) begin
			send_byte(8'($urandom_range(255)), 1'b0, '0);
			return;
		end
		pick = $urandom_range(2);
		kind = (pick == 0) ? hcih4_pkg::KIND_EVT :
			(pick == 1) ? hcih4_pkg::KIND_ACL : hcih4_pkg::KIND_SCO;
		tbyte = (pick == 0) ? hcih4_pkg::TYPE_EVT :
			(pick == 1) ? hcih4_pkg::TYPE_ACL : hcih4_pkg::TYPE_SCO;
		hs = hdr_len(kind);
		lim = eff_limit();
		pick = $urandom_range(99);
		if (pick < 60)
			plen = $urandom_range(16);
		else if (pick < 75)
			plen = $urandom_range(64, 17);
		else if (pick < 88)
			plen = (lim >= hs) ? lim - hs + $urandom_range(1) : $urandom_range(3);
		else
			plen = $urandom_range(65535);
		if (kind != hcih4_pkg::KIND_ACL)
			plen = plen & 255;
		// Keep delivered frames short; a long one becomes an abandon instead
		if (hs + plen <= lim && plen > 300)
			plen = lim - hs + 1;
		foreach (hb[i])
			hb[i] = 8'($urandom_range(255));
		if (kind == hcih4_pkg::KIND_EVT) begin
			hb[1] = plen[7:0];
		end else begin
			hb[2] = plen[7:0];
			hb[3] = plen[15:8];
		end
		send_byte(tbyte, 1'b0, '0);
		for (int i = 0; i < hs; i++)
			send_byte(hb[i], 1'b0, '0);
		n_payload = (hs + plen <= lim) ? plen : 0;
		// Now and then cut the payload short, so the next type byte is swallowed
		if (n_payload > 1 && $urandom_range(99) < 8)
			n_payload = $urandom_range(n_payload - 1);
		repeat (n_payload) send_byte(8'($urandom_range(255)), 1'b0, '0);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Output side: random drain, plus one long hold-off so the block backs up
	always @(posedge clk) begin
		if (out_valid && out_ready)
			words_taken++;
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && words_taken == HOLD_AT_WORD) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= drain_gap_pct);
		end
	end

	// Compare every drained word with the oldest expectation
	always @(posedge clk) begin : word_check
		hcih4_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tagged_bytes_q.size() == 0) begin
				$error("data_byte: expected none, got %0h", data_byte);
				mismatches++;
			end else begin
				want = tagged_bytes_q.pop_front();
				check_field("data_byte", want.data_byte, data_byte);
				check_field("packet_kind", want.packet_kind, packet_kind);
				check_field("byte_role", want.byte_role, byte_role);
				check_field("frame_offset", want.frame_offset, frame_offset);
				check_field("frame_end", want.frame_end, frame_end);
				check_field("bad_type", want.bad_type, bad_type);
				check_field("too_long", want.too_long, too_long);
			end
		end
	end

	initial begin : stimulus
		int unsigned target;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		feed_gap_pct = 32;
		drain_gap_pct = 68;
		fr_state = AWAIT_TYPE;
		fr_left = '0;
		fr_fill = '0;
		fr_kind = hcih4_pkg::KIND_EVT;
		fr_limit = hcih4_pkg::MAX_FRAME_LEN_RST;
		foreach (fr_hdr[i])
			fr_hdr[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bytes at the reset limit
		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

		// Random frames at the reset limit; the long hold-off lands here
		target = bytes_sent + 250;
		while (bytes_sent < target)
			send_frame();

		// Smallest sensible limit: only the shortest frames survive
		set_limit(13'd4);
		target = bytes_sent + 150;
		while (bytes_sent < target)
			send_frame();

		// Ceiling limit: one ACL frame a byte over it is abandoned
		set_limit(13'd4096);
		send_byte(hcih4_pkg::TYPE_ACL, 1'b0, '0);
		send_byte(8'($urandom_range(255)), 1'b0, '0);
		send_byte(8'($urandom_range(255)), 1'b0, '0);
		send_byte(8'hFD, 1'b0, '0);
		send_byte(8'h0F, 1'b0, '0);
		target = bytes_sent + 150;
		while (bytes_sent < target)
			send_frame();

		// Swap the idling: a slow sender against a busy drain
		feed_gap_pct = 68;
		drain_gap_pct = 32;
		// Register above the ceiling: the ceiling wins
		set_limit(13'h1FFF);
		target = bytes_sent + 150;
		while (bytes_sent < target)
			send_frame();

		// Limit of two: only an event frame with an empty payload survives; every other frame is abandoned
		set_limit(13'd2);
		target = bytes_sent + 60;
		while (bytes_sent < target)
			send_frame();

		// Full rate on both sides with a mid-range limit
		feed_gap_pct = 0;
		drain_gap_pct = 0;
		set_limit(13'($urandom_range(200, 20)));
		target = bytes_sent + 150;
		while (bytes_sent < target)
			send_frame();

		// Drain and let the pipeline settle before the verdict
		in_valid <= 1'b0;
		while (tagged_bytes_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && tagged_bytes_q.size() == 0)
			$display("hci_h4_packet_deframer verification clean");
		else
			$display("hci_h4_packet_deframer verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5ms;
		$display("hci_h4_packet_deframer verification failed");
		$finish;
	end

endmodule
